// ===== sv/ipf_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ipf_pkg: shared types for the image packet framer
// Byte kinds, register indexes, item and beat records, checksum adder.
// ---------------------------------------------------------------------------
package ipf_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned KindW  = 3;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_START_CODE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_TRAIN_CODE = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_TEST_CODE  = 2'd2;

  localparam logic [ByteW-1:0] START_CODE_RST = 8'hFF;
  localparam logic [ByteW-1:0] TRAIN_CODE_RST = 8'h01;
  localparam logic [ByteW-1:0] TEST_CODE_RST  = 8'h02;

  localparam logic [ByteW-1:0] PIXEL_RESERVED = 8'hFF;
  localparam logic [ByteW-1:0] PIXEL_CLAMPED  = 8'hFE;

  typedef enum logic [KindW-1:0] {
    KIND_START    = 3'd0,
    KIND_MODE     = 3'd1,
    KIND_LABEL    = 3'd2,
    KIND_DATA     = 3'd3,
    KIND_CHECKSUM = 3'd4
  } kind_e;

  // one accepted pixel with everything its beats need
  typedef struct packed {
    logic             first;
    logic             last;
    logic [ByteW-1:0] start_code;
    logic [ByteW-1:0] mode_code;
    logic [ByteW-1:0] label;
    logic [ByteW-1:0] pixel;
    logic [ByteW-1:0] checksum;
  } item_t;

  typedef struct packed {
    logic [ByteW-1:0] data;
    kind_e            kind;
    logic             last;
  } beat_t;

  // 8-bit one's-complement add with end-around carry
  function automatic logic [ByteW-1:0] oc_add8(input logic [ByteW-1:0] a,
                                               input logic [ByteW-1:0] b);
    logic [ByteW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ByteW-1:0] + {{(ByteW-1){1'b0}}, s[ByteW]};
  endfunction

endpackage

// ===== sv/ipf_sequencer.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ipf_sequencer: item register and beat sequencer
// Holds one framed pixel and walks its header, data and checksum beats.
// ---------------------------------------------------------------------------
module ipf_sequencer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  ipf_pkg::item_t item_i,
  output logic           ready_o,
  input  logic           take_i,
  output logic           beat_valid_o,
  output ipf_pkg::beat_t beat_o
);

  logic           valid_q;
  ipf_pkg::kind_e phase_q;
  ipf_pkg::kind_e phase_next;
  ipf_pkg::item_t item_q;
  logic           beat_last;
  logic           advance;

  always_comb begin
    beat_o.kind = phase_q;
    beat_last   = 1'b0;
    phase_next  = ipf_pkg::KIND_DATA;
    unique case (phase_q)
      ipf_pkg::KIND_START: begin
        beat_o.data = item_q.start_code;
        phase_next  = ipf_pkg::KIND_MODE;
      end
      ipf_pkg::KIND_MODE: begin
        beat_o.data = item_q.mode_code;
        phase_next  = ipf_pkg::KIND_LABEL;
      end
      ipf_pkg::KIND_LABEL: begin
        beat_o.data = item_q.label;
        phase_next  = ipf_pkg::KIND_DATA;
      end
      ipf_pkg::KIND_DATA: begin
        beat_o.data = item_q.pixel;
        beat_last   = !item_q.last;
        phase_next  = ipf_pkg::KIND_CHECKSUM;
      end
      ipf_pkg::KIND_CHECKSUM: begin
        beat_o.data = item_q.checksum;
        beat_last   = 1'b1;
      end
      default: begin
        beat_o.data = item_q.checksum;
        beat_last   = 1'b1;
      end
    endcase
    beat_o.last = beat_last;
  end

  assign beat_valid_o = valid_q;
  assign advance      = valid_q && take_i;
  // a new pixel may enter while the last beat of the current one moves on
  assign ready_o      = !valid_q || (advance && beat_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= ipf_pkg::KIND_START;
    end else if (load_i) begin
      valid_q <= 1'b1;
      phase_q <= item_i.first ? ipf_pkg::KIND_START : ipf_pkg::KIND_DATA;
    end else if (advance) begin
      if (beat_last) begin
        valid_q <= 1'b0;
      end else begin
        phase_q <= phase_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

endmodule

// ===== sv/image_packet_framer.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// image_packet_framer: pixel stream to serial packet framer
// Adds start, mode and label header bytes, clamps pixels, appends checksum.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one pixel per beat. tdata = {label_byte, pixel},
//   tuser = {train_mode, first_pixel}, tlast = last_pixel. label and
//   train_mode matter only on a first pixel.
//   m_axis carries one output byte per beat: tdata = byte, tuser = byte
//   kind (start, mode, label, data, checksum), tlast marks the final byte
//   caused by one input pixel.
//   A pixel yields one to five output beats, one per cycle while m_axis
//   is ready. The first output beat passes the item register, then the
//   output register. Plain pixels sustain one beat per cycle while m_axis
//   is ready; a first pixel adds start, mode and label beats and a last
//   pixel a checksum beat, as there is a single output byte lane. When m_axis
//   stalls, both registers hold and s_axis_tready drops unless the item
//   register is empty or its last beat leaves; nothing is lost. Reset
//   empties both registers, clears the running checksum and loads the
//   default codes (start 0xFF, train 0x01, test 0x02). Index 3 is ignored.
//   The config port is to be written only while the block is idle; unchecked.
// ---------------------------------------------------------------------------
module image_packet_framer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  // pixel input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] pixel, [15:8] label_byte
  input  logic [1:0]  s_axis_tuser,   // [0] first_pixel, [1] train_mode
  input  logic        s_axis_tlast,   // last_pixel
  // byte output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic [2:0]  m_axis_tuser,   // [2:0] byte_kind
  output logic        m_axis_tlast    // run_last
);

  logic [ipf_pkg::ByteW-1:0] start_code_q;
  logic [ipf_pkg::ByteW-1:0] train_code_q;
  logic [ipf_pkg::ByteW-1:0] test_code_q;
  logic [ipf_pkg::ByteW-1:0] running_sum_q;
  logic [ipf_pkg::ByteW-1:0] running_sum_d;
  logic [ipf_pkg::ByteW-1:0] pixel_in;
  logic [ipf_pkg::ByteW-1:0] label_in;
  logic [ipf_pkg::ByteW-1:0] pixel_clamped;
  logic [ipf_pkg::ByteW-1:0] sum_base;
  logic                      first_in;
  logic                      train_in;
  logic                      in_accept;
  ipf_pkg::item_t            item_d;
  logic                      seq_ready;
  logic                      seq_take;
  logic                      beat_valid;
  ipf_pkg::beat_t            beat;
  logic                      out_valid_q;
  ipf_pkg::beat_t            out_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_code_q <= ipf_pkg::START_CODE_RST;
      train_code_q <= ipf_pkg::TRAIN_CODE_RST;
      test_code_q  <= ipf_pkg::TEST_CODE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ipf_pkg::CFG_START_CODE: start_code_q <= cfg_wdata_i;
        ipf_pkg::CFG_TRAIN_CODE: train_code_q <= cfg_wdata_i;
        ipf_pkg::CFG_TEST_CODE:  test_code_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign pixel_in  = s_axis_tdata[7:0];
  assign label_in  = s_axis_tdata[15:8];
  assign first_in  = s_axis_tuser[0];
  assign train_in  = s_axis_tuser[1];
  assign in_accept = s_axis_tvalid && s_axis_tready;

  assign pixel_clamped = (pixel_in == ipf_pkg::PIXEL_RESERVED) ? ipf_pkg::PIXEL_CLAMPED
                                                               : pixel_in;
  // a first pixel restarts the sum from the label
  assign sum_base      = first_in ? label_in : running_sum_q;
  assign running_sum_d = ipf_pkg::oc_add8(sum_base, pixel_clamped);

  always_comb begin
    item_d.first      = first_in;
    item_d.last       = s_axis_tlast;
    item_d.start_code = start_code_q;
    item_d.mode_code  = train_in ? train_code_q : test_code_q;
    item_d.label      = label_in;
    item_d.pixel      = pixel_clamped;
    item_d.checksum   = running_sum_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_sum_q <= '0;
    end else if (in_accept) begin
      running_sum_q <= running_sum_d;
    end
  end

  ipf_sequencer u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (in_accept),
    .item_i       (item_d),
    .ready_o      (seq_ready),
    .take_i       (seq_take),
    .beat_valid_o (beat_valid),
    .beat_o       (beat)
  );

  assign s_axis_tready = seq_ready;

  // output register takes a beat when empty or when its beat leaves
  assign seq_take = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (seq_take) begin
      out_valid_q <= beat_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_take && beat_valid) begin
      out_q <= beat;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.data;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last;

endmodule

// ===== sim/tb_image_packet_framer.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_image_packet_framer: self-checking bench for the image packet framer
// Drives pixel beats with bursts and gaps, stalls the byte output on its own
// pattern, predicts every output byte and checks it in order against a queue.
// ---------------------------------------------------------------------------
module tb_image_packet_framer;

  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [7:0] pix;
    logic       first;
    logic       last;
    logic       train;
    logic [7:0] label;
  } pix_item_t;

  typedef struct packed {
    logic [7:0]     data;
    ipf_pkg::kind_e kind;
    logic           last;
  } byte_rec_t;

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_e;
  typedef enum logic {ROW_ITEM, ROW_CFG} row_e;

  typedef struct {
    row_e        op;
    logic [1:0]  idx;
    logic [7:0]  val;
    pix_item_t   it;
    int          n_typed;
    logic [39:0] typed;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = '0;
  logic [7:0]  cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic [15:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        s_tlast = 1'b0;
  logic        m_tready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [7:0]  m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  // block state as the bench sees it
  logic [7:0]  cur_start = ipf_pkg::START_CODE_RST;
  logic [7:0]  cur_train = ipf_pkg::TRAIN_CODE_RST;
  logic [7:0]  cur_test = ipf_pkg::TEST_CODE_RST;
  logic [7:0]  pkt_sum = '0;

  byte_rec_t   pending_bytes[$];
  row_t        dir_tab[$];
  int          mismatch_cnt = 0;
  int          items_sent = 0;
  int          burst_left = 0;
  bit          tx_idle = 1'b0;
  rx_mode_e    rx_mode = RX_OPEN;
  int          hold_req = 0;

  image_packet_framer u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk = ~clk;

  initial begin
    #1_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // end-around carry: a wrapped sum loses 256 and gains 1
  function automatic logic [7:0] ones_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[8]) s = s - 9'h0FF;
    return s[7:0];
  endfunction

  function automatic byte_rec_t mk_byte(input logic [7:0] d, input ipf_pkg::kind_e k);
    byte_rec_t r;
    r.data = d;
    r.kind = k;
    r.last = 1'b0;
    return r;
  endfunction

  // expected output bytes of one accepted pixel; typed bytes override data
  function automatic void frame_pixel(input pix_item_t it, input int n_typed,
                                      input logic [39:0] typed);
    byte_rec_t  b[5];
    int         n;
    logic [7:0] d;
    n = 0;
    if (it.first) begin
      b[0] = mk_byte(cur_start, ipf_pkg::KIND_START);
      b[1] = mk_byte(it.train ? cur_train : cur_test, ipf_pkg::KIND_MODE);
      b[2] = mk_byte(it.label, ipf_pkg::KIND_LABEL);
      n = 3;
      pkt_sum = it.label;
    end
    d = (it.pix == ipf_pkg::PIXEL_RESERVED) ? ipf_pkg::PIXEL_CLAMPED : it.pix;
    b[n] = mk_byte(d, ipf_pkg::KIND_DATA);
    n++;
    pkt_sum = ones_add(pkt_sum, d);
    if (it.last) begin
      b[n] = mk_byte(pkt_sum, ipf_pkg::KIND_CHECKSUM);
      n++;
    end
    b[n-1].last = 1'b1;
    for (int k = 0; k < n; k++) begin
      if (k < n_typed) b[k].data = typed[8*k +: 8];
      pending_bytes.push_back(b[k]);
    end
  endfunction

  function automatic logic [7:0] rand_pixel();
    int r;
    r = $urandom_range(0, 11);
    if (r < 2) return ipf_pkg::PIXEL_RESERVED;
    if (r == 2) return ipf_pkg::PIXEL_CLAMPED;
    if (r == 3) return 8'h00;
    return 8'($urandom);
  endfunction

  function automatic pix_item_t noise_item();
    pix_item_t it;
    it = pix_item_t'($urandom);
    it.pix = rand_pixel();
    return it;
  endfunction

  task automatic offer(input pix_item_t it, input int n_typed, input logic [39:0] typed);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {it.label, it.pix};
    s_tuser  <= {it.train, it.first};
    s_tlast  <= it.last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    frame_pixel(it, n_typed, typed);
    items_sent++;
  endtask

  task automatic send(input pix_item_t it);
    int gap;
    if (tx_idle) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 6);
        burst_left = $urandom_range(1, 12);
        repeat (gap) begin
          @(negedge clk);
          s_tvalid <= 1'b0;
          s_tdata  <= 16'($urandom);
          s_tuser  <= 2'($urandom);
          s_tlast  <= 1'($urandom);
        end
      end
      burst_left--;
    end
    offer(it, 0, '0);
  endtask

  // stop offering and wait until every expected byte is out
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ipf_pkg::CFG_START_CODE: cur_start = val;
      ipf_pkg::CFG_TRAIN_CODE: cur_train = val;
      ipf_pkg::CFG_TEST_CODE:  cur_test = val;
      default: ;
    endcase
  endtask

  task automatic write_codes(input logic [7:0] st, input logic [7:0] tr,
                             input logic [7:0] te);
    write_reg(ipf_pkg::CFG_START_CODE, st);
    write_reg(ipf_pkg::CFG_TRAIN_CODE, tr);
    write_reg(ipf_pkg::CFG_TEST_CODE, te);
  endtask

  // n = 0 leaves the row to the predictor
  task automatic add_item(input logic [7:0] pix, input bit first, input bit last,
                          input bit train, input logic [7:0] label, input int n,
                          input logic [7:0] b0 = 0, input logic [7:0] b1 = 0,
                          input logic [7:0] b2 = 0, input logic [7:0] b3 = 0,
                          input logic [7:0] b4 = 0);
    row_t r;
    r.op = ROW_ITEM;
    r.idx = '0;
    r.val = '0;
    r.it.pix = pix;
    r.it.first = first;
    r.it.last = last;
    r.it.train = train;
    r.it.label = label;
    r.n_typed = n;
    r.typed = {b4, b3, b2, b1, b0};
    dir_tab.push_back(r);
  endtask

  task automatic add_cfg(input logic [1:0] idx, input logic [7:0] val);
    row_t r;
    r.op = ROW_CFG;
    r.idx = idx;
    r.val = val;
    r.it = '0;
    r.n_typed = 0;
    r.typed = '0;
    dir_tab.push_back(r);
  endtask

  // byte checker
  always @(posedge clk) begin
    byte_rec_t e;
    if (rst_n && m_axis_tvalid && m_tready) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected beat: out_byte %h byte_kind %0d run_last %b",
               m_axis_tdata, m_axis_tuser, m_axis_tlast);
        mismatch_cnt++;
      end else begin
        e = pending_bytes.pop_front();
        if (m_axis_tdata !== e.data) begin
          $error("out_byte: expected %h, got %h", e.data, m_axis_tdata);
          mismatch_cnt++;
        end
        if (m_axis_tuser !== e.kind) begin
          $error("byte_kind: expected %0d, got %0d", e.kind, m_axis_tuser);
          mismatch_cnt++;
        end
        if (m_axis_tlast !== e.last) begin
          $error("run_last: expected %b, got %b", e.last, m_axis_tlast);
          mismatch_cnt++;
        end
      end
    end
  end

  // receiver: mode pattern plus long hold-offs on request
  initial begin : rx_proc
    int hold_cnt;
    int tick;
    hold_cnt = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_req > 0) begin
        hold_cnt = hold_req;
        hold_req = 0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_tready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:    m_tready <= 1'b1;
          RX_RANDOM:  m_tready <= ($urandom_range(0, 99) < 65);
          RX_PATTERN: m_tready <= ((tick % 7) != 2) && ((tick % 7) != 5);
          default:    m_tready <= 1'b1;
        endcase
      end
    end
  end

  initial begin : main_proc
    pix_item_t it;
    int        len;
    int        pick;
    int        budget;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset codes: start ff, train 01, test 02, sum 0
    add_item(8'h10, 0, 0, 0, 8'h00, 1, 8'h10);                 // no header yet
    add_item(8'hFF, 0, 1, 1, 8'h33, 2, 8'hFE, 8'h0F);          // clamp, carry wraps
    add_item(8'h00, 1, 1, 1, 8'h00, 5, 8'hFF, 8'h01, 8'h00, 8'h00, 8'h00);
    add_item(8'hFF, 1, 1, 0, 8'hFF, 5, 8'hFF, 8'h02, 8'hFF, 8'hFE, 8'hFE);
    add_item(8'h80, 1, 0, 1, 8'hAB, 4, 8'hFF, 8'h01, 8'hAB, 8'h80);
    add_item(8'h7F, 0, 0, 0, 8'h00, 1, 8'h7F);
    add_item(8'hFF, 0, 1, 0, 8'h00, 2, 8'hFE, 8'hAA);
    add_item(8'h01, 0, 0, 0, 8'h00, 1, 8'h01);                 // sum kept after checksum
    add_item(8'h54, 0, 1, 0, 8'h00, 2, 8'h54, 8'hFF);
    add_item(8'h00, 0, 0, 1, 8'h5A, 1, 8'h00);                 // label, mode ignored
    add_item(8'hFE, 0, 0, 1, 8'hA5, 0);
    add_cfg(ipf_pkg::CFG_START_CODE, 8'h00);
    add_cfg(ipf_pkg::CFG_TRAIN_CODE, 8'hFF);
    add_cfg(ipf_pkg::CFG_TEST_CODE, 8'h00);
    add_cfg(CFG_UNUSED, 8'h55);
    // clamp stays on with a start code other than ff
    add_item(8'hFF, 1, 1, 1, 8'h01, 5, 8'h00, 8'hFF, 8'h01, 8'hFE, 8'hFF);
    add_item(8'h33, 1, 0, 0, 8'h7E, 0);
    add_item(8'hFE, 0, 0, 1, 8'hC3, 0);
    add_item(8'hFF, 0, 1, 0, 8'h3C, 0);
    add_item(8'h00, 1, 0, 0, 8'hFF, 0);                         // packet cut short, no checksum
    add_item(8'h9A, 1, 1, 1, 8'h66, 0);

    rx_mode = RX_RANDOM;
    tx_idle = 1'b1;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].op == ROW_CFG) begin
        settle();
        write_reg(dir_tab[i].idx, dir_tab[i].val);
      end else if (dir_tab[i].n_typed > 0) begin
        offer(dir_tab[i].it, dir_tab[i].n_typed, dir_tab[i].typed);
      end else begin
        send(dir_tab[i].it);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      settle();
      case (ph)
        0: begin
          write_codes(8'($urandom), 8'($urandom), 8'($urandom));
          rx_mode = RX_OPEN;
          tx_idle = 1'b0;
        end
        1: begin
          write_codes(8'h00, 8'h00, 8'hFF);
          rx_mode = RX_RANDOM;
          tx_idle = 1'b0;
          hold_req = 80;   // output blocked while input keeps offering
        end
        2: begin
          write_codes(ipf_pkg::START_CODE_RST, 8'($urandom), 8'($urandom));
          rx_mode = RX_PATTERN;
          tx_idle = 1'b1;
        end
        default: begin
          write_codes(8'hFF, 8'hFF, 8'h00);
          rx_mode = RX_RANDOM;
          tx_idle = 1'b1;
        end
      endcase
      budget = items_sent + 40;
      while (items_sent < budget) begin
        pick = $urandom_range(0, 9);
        if (pick <= 6) begin
          len = $urandom_range(1, 8);
          for (int k = 0; k < len; k++) begin
            it = noise_item();
            it.first = (k == 0);
            it.last = (k == len - 1);
            send(it);
          end
        end else if (pick == 7) begin
          len = $urandom_range(1, 3);
          for (int k = 0; k < len; k++) begin
            it = noise_item();
            it.first = 1'b0;
            it.last = (k == len - 1) && $urandom_range(0, 1);
            send(it);
          end
        end else if (pick == 8) begin
          len = $urandom_range(1, 4);
          for (int k = 0; k < len; k++) begin
            it = noise_item();
            it.first = (k == 0);
            it.last = 1'b0;
            send(it);
          end
        end else begin
          send(noise_item());
        end
        if (ph == 2 && $urandom_range(0, 5) == 0) settle();
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0 && pending_bytes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
